>>> rtl/erp_pkg.sv
// Shared types, constants and helpers for the ellipse ray projector.
`timescale 1ns / 1ps

package erp_pkg;

    // Input transaction payload
    typedef struct packed {
        logic signed [31:0] source_x;
        logic signed [31:0] source_y;
        logic        [15:0] ray_angle;
        logic signed [31:0] shift_x;
        logic signed [31:0] prior_sum;
    } erp_in_t;

    // Result transaction payload
    typedef struct packed {
        logic signed [31:0] new_sum;
        logic               hit;
    } erp_out_t;

    // Cosine and sine, signed Q2.30
    typedef struct packed {
        logic signed [31:0] co;
        logic signed [31:0] si;
    } erp_trig_t;

    // Values that ride along with the chord computation
    typedef struct packed {
        logic        [63:0] c;
        logic               hit;
        logic signed [31:0] prior;
    } erp_side_t;

    // Geometry result: radicand plus side values
    typedef struct packed {
        logic [63:0] diff;
        erp_side_t   side;
    } erp_geom_t;

    // Chord result handed to the accumulator
    typedef struct packed {
        logic        [31:0] chord;
        logic               hit;
        logic signed [31:0] prior;
    } erp_chord_t;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRE_RADIUS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRE_ANGLE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIENTATION   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEMI_AXIS_A   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SEMI_AXIS_B   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DENSITY       = 3'd5;

    // Fixed-point constants
    localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
    localparam logic [30:0] HALFPI_Q30 = 31'd1686629713;

    // Horner divisors as reciprocals, floor(x * REC >> REC_SHIFT) == floor(x / k)
    localparam int unsigned REC_SHIFT = 40;
    localparam int unsigned N_LEVELS = 5;
    localparam logic [39:0] SIN_REC [N_LEVELS] = '{
        40'(((64'd1 << 40) + 64'd109) / 64'd110),
        40'(((64'd1 << 40) + 64'd71) / 64'd72),
        40'(((64'd1 << 40) + 64'd41) / 64'd42),
        40'(((64'd1 << 40) + 64'd19) / 64'd20),
        40'(((64'd1 << 40) + 64'd5) / 64'd6)
    };
    localparam logic [39:0] COS_REC [N_LEVELS] = '{
        40'(((64'd1 << 40) + 64'd89) / 64'd90),
        40'(((64'd1 << 40) + 64'd55) / 64'd56),
        40'(((64'd1 << 40) + 64'd29) / 64'd30),
        40'(((64'd1 << 40) + 64'd11) / 64'd12),
        40'(((64'd1 << 40) + 64'd1) / 64'd2)
    };

    // Pipeline depths
    localparam int unsigned TRIG_ST  = 14;
    localparam int unsigned GEOM_ST  = 7;
    localparam int unsigned ROOT_ST  = 32;
    localparam int unsigned QUO_ST   = 31;
    localparam int unsigned CHORD_ST = ROOT_ST + 3 + QUO_ST;
    localparam int unsigned ACC_ST   = 3;
    localparam int unsigned NST      = 1 + TRIG_ST + GEOM_ST + CHORD_ST + ACC_ST;

    // Magnitude of a signed 32-bit value
    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

endpackage

>>> rtl/erp_trig.sv
// Pipelined cosine and sine of a 16-bit turn fraction.
`timescale 1ns / 1ps

module erp_trig
    import erp_pkg::*;
(
    input  logic               aclk,
    input  logic [TRIG_ST-1:0] en,
    input  logic [15:0]        angle,
    output erp_trig_t          trig
);

    logic [30:0] t_reg    [0:11];
    logic [31:0] t2_reg   [1:9];
    logic [1:0]  quad_reg [0:12];
    logic [31:0] sp_reg   [N_LEVELS];
    logic [31:0] cp_reg   [N_LEVELS];
    logic [30:0] sin_reg  [N_LEVELS];
    logic [30:0] cos_reg  [N_LEVELS];
    logic [30:0] sfin_reg;
    logic [30:0] cfin_reg;
    logic [31:0] sfin_next;
    erp_trig_t   trig_reg;

    // Argument scaling and square
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            t_reg[0]    <= 31'((45'(angle[13:0]) * 45'(HALFPI_Q30)) >> 14);
            quad_reg[0] <= angle[15:14];
        end
        if (en[1]) begin
            t2_reg[1] <= 32'((62'(t_reg[0]) * 62'(t_reg[0])) >> 30);
        end
        for (int k = 1; k <= 11; k++) begin
            if (en[k]) t_reg[k] <= t_reg[k-1];
        end
        for (int k = 2; k <= 9; k++) begin
            if (en[k]) t2_reg[k] <= t2_reg[k-1];
        end
        for (int k = 1; k <= 12; k++) begin
            if (en[k]) quad_reg[k] <= quad_reg[k-1];
        end
    end

    // Horner levels, two stages each: multiply by t2, then divide by constant
    for (genvar j = 0; j < N_LEVELS; j++) begin : g_level
        logic [30:0] s_in;
        logic [30:0] c_in;
        logic [31:0] sq;
        logic [31:0] cq;

        if (j == 0) begin : g_first
            assign s_in = ONE_Q30;
            assign c_in = ONE_Q30;
        end else begin : g_next
            assign s_in = sin_reg[j-1];
            assign c_in = cos_reg[j-1];
        end

        assign sq = 32'((72'(sp_reg[j]) * 72'(SIN_REC[j])) >> REC_SHIFT);
        assign cq = 32'((72'(cp_reg[j]) * 72'(COS_REC[j])) >> REC_SHIFT);

        always_ff @(posedge aclk) begin
            if (en[2+2*j]) begin
                sp_reg[j] <= 32'((63'(t2_reg[1+2*j]) * 63'(s_in)) >> 30);
                cp_reg[j] <= 32'((63'(t2_reg[1+2*j]) * 63'(c_in)) >> 30);
            end
            if (en[3+2*j]) begin
                sin_reg[j] <= (sq >= 32'(ONE_Q30)) ? '0 : 31'(32'(ONE_Q30) - sq);
                cos_reg[j] <= (cq >= 32'(ONE_Q30)) ? '0 : 31'(32'(ONE_Q30) - cq);
            end
        end
    end

    // Final sine multiply with clamp at one
    assign sfin_next = 32'((62'(t_reg[11]) * 62'(sin_reg[N_LEVELS-1])) >> 30);

    always_ff @(posedge aclk) begin
        if (en[12]) begin
            sfin_reg <= (sfin_next > 32'(ONE_Q30)) ? ONE_Q30 : 31'(sfin_next);
            cfin_reg <= cos_reg[N_LEVELS-1];
        end
    end

    // Quadrant sets the signs and, in quadrants 1 and 3, swaps sine and cosine
    always_ff @(posedge aclk) begin
        if (en[13]) begin
            unique case (quad_reg[12])
                2'd0: begin
                    trig_reg.co <= $signed({1'b0, cfin_reg});
                    trig_reg.si <= $signed({1'b0, sfin_reg});
                end
                2'd1: begin
                    trig_reg.co <= -$signed({1'b0, sfin_reg});
                    trig_reg.si <= $signed({1'b0, cfin_reg});
                end
                2'd2: begin
                    trig_reg.co <= -$signed({1'b0, cfin_reg});
                    trig_reg.si <= -$signed({1'b0, sfin_reg});
                end
                default: begin
                    trig_reg.co <= $signed({1'b0, sfin_reg});
                    trig_reg.si <= -$signed({1'b0, cfin_reg});
                end
            endcase
        end
    end

    assign trig = trig_reg;

endmodule

>>> rtl/erp_geom.sv
// Ray distance, ellipse width term and hit test.
`timescale 1ns / 1ps

module erp_geom
    import erp_pkg::*;
(
    input  logic               aclk,
    input  logic [GEOM_ST-1:0] en,
    input  erp_trig_t          tphi,
    input  erp_trig_t          tcen,
    input  erp_trig_t          tori,
    input  erp_in_t            item,
    input  logic [30:0]        radius,
    input  logic [30:0]        axis_a,
    input  logic [30:0]        axis_b,
    output erp_geom_t          geom
);

    localparam int unsigned LANES = 6;

    logic        [31:0] mv_next   [LANES];
    logic        [30:0] mk_next   [LANES];
    logic               neg_next  [LANES];
    logic        [31:0] mv_reg    [LANES];
    logic        [30:0] mk_reg    [LANES];
    logic               neg_reg   [LANES];
    logic        [62:0] prod_reg  [LANES];
    logic               neg1_reg  [LANES];
    logic signed [34:0] term_reg  [LANES];
    logic signed [31:0] prior_reg [0:5];
    logic signed [36:0] s_reg;
    logic        [31:0] ac_reg;
    logic        [31:0] bs_reg;
    logic        [35:0] ms_next;
    logic        [31:0] ms_reg;
    logic               far_reg;
    logic               far5_reg;
    logic        [63:0] ac2_reg;
    logic        [63:0] bs2_reg;
    logic        [63:0] c_reg;
    logic        [63:0] s2_reg;
    erp_geom_t          geom_reg;

    // Operand magnitudes and product signs
    always_comb begin
        mv_next[0]  = abs32(item.source_x);
        mk_next[0]  = 31'(abs32(tphi.co));
        neg_next[0] = item.source_x[31] ^ tphi.co[31];
        mv_next[1]  = abs32(item.source_y);
        mk_next[1]  = 31'(abs32(tphi.si));
        neg_next[1] = item.source_y[31] ^ tphi.si[31];
        mv_next[2]  = {1'b0, radius};
        mk_next[2]  = 31'(abs32(tcen.co));
        neg_next[2] = tcen.co[31];
        mv_next[3]  = abs32(item.shift_x);
        mk_next[3]  = 31'(abs32(tphi.co));
        neg_next[3] = item.shift_x[31] ^ tphi.co[31];
        mv_next[4]  = {1'b0, axis_a};
        mk_next[4]  = 31'(abs32(tori.co));
        neg_next[4] = 1'b0;
        mv_next[5]  = {1'b0, axis_b};
        mk_next[5]  = 31'(abs32(tori.si));
        neg_next[5] = 1'b0;
    end

    // Stages 0..2: magnitudes, products, rounding half away from zero
    always_ff @(posedge aclk) begin
        for (int i = 0; i < LANES; i++) begin
            if (en[0]) begin
                mv_reg[i]  <= mv_next[i];
                mk_reg[i]  <= mk_next[i];
                neg_reg[i] <= neg_next[i];
            end
            if (en[1]) begin
                prod_reg[i] <= 63'(mv_reg[i]) * 63'(mk_reg[i]);
                neg1_reg[i] <= neg_reg[i];
            end
            if (en[2]) begin
                term_reg[i] <= neg1_reg[i]
                    ? $signed(35'd0 - 35'((64'(prod_reg[i]) + 64'd536870912) >> 30))
                    : $signed(35'((64'(prod_reg[i]) + 64'd536870912) >> 30));
            end
        end
        if (en[0]) prior_reg[0] <= item.prior_sum;
        for (int k = 1; k <= 5; k++) begin
            if (en[k]) prior_reg[k] <= prior_reg[k-1];
        end
    end

    // Stage 3: signed distance; stage 4: magnitude and squares
    assign ms_next = s_reg[36] ? 36'(-s_reg) : 36'(s_reg);

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            s_reg  <= 37'(term_reg[0]) + 37'(term_reg[1])
                    - 37'(term_reg[2]) - 37'(term_reg[3]);
            ac_reg <= term_reg[4][31:0];
            bs_reg <= term_reg[5][31:0];
        end
        if (en[4]) begin
            ms_reg  <= ms_next[31:0];
            far_reg <= |ms_next[35:32];
            ac2_reg <= 64'(ac_reg) * 64'(ac_reg);
            bs2_reg <= 64'(bs_reg) * 64'(bs_reg);
        end
        if (en[5]) begin
            c_reg    <= ac2_reg + bs2_reg;
            s2_reg   <= 64'(ms_reg) * 64'(ms_reg);
            far5_reg <= far_reg;
        end
        if (en[6]) begin
            geom_reg.diff       <= c_reg - s2_reg;
            geom_reg.side.c     <= c_reg;
            geom_reg.side.hit   <= !far5_reg && (s2_reg < c_reg);
            geom_reg.side.prior <= prior_reg[5];
        end
    end

    assign geom = geom_reg;

endmodule

>>> rtl/erp_chord.sv
// Square root, scaling product and quotient giving the chord length.
`timescale 1ns / 1ps

module erp_chord
    import erp_pkg::*;
(
    input  logic                aclk,
    input  logic [CHORD_ST-1:0] en,
    input  erp_geom_t           geom,
    input  logic [61:0]         ab,
    output erp_chord_t          chord
);

    localparam int unsigned MUL_ST = ROOT_ST;
    localparam int unsigned SUM_ST = ROOT_ST + 1;
    localparam int unsigned SAT_ST = ROOT_ST + 2;
    localparam int unsigned DIV_ST = ROOT_ST + 3;

    erp_side_t   side_reg [0:CHORD_ST-1];
    logic [63:0] rv_reg   [ROOT_ST];
    logic [63:0] rr_reg   [ROOT_ST];
    logic [62:0] pl_reg;
    logic [62:0] ph_reg;
    logic [93:0] num_reg;
    logic [93:0] rem_reg  [0:QUO_ST];
    logic        sat_reg  [0:QUO_ST];
    logic [30:0] q_reg    [QUO_ST];

    // Side values follow the stages
    always_ff @(posedge aclk) begin
        if (en[0]) side_reg[0] <= geom.side;
        for (int k = 1; k < CHORD_ST; k++) begin
            if (en[k]) side_reg[k] <= side_reg[k-1];
        end
    end

    // Integer square root, one result bit per stage
    for (genvar i = 0; i < ROOT_ST; i++) begin : g_root
        localparam logic [63:0] RBIT = 64'd1 << (2 * (ROOT_ST - 1 - i));
        logic [63:0] v_in;
        logic [63:0] r_in;
        logic [63:0] trial;

        if (i == 0) begin : g_first
            assign v_in = geom.diff;
            assign r_in = '0;
        end else begin : g_next
            assign v_in = rv_reg[i-1];
            assign r_in = rr_reg[i-1];
        end

        assign trial = r_in + RBIT;

        always_ff @(posedge aclk) begin
            if (en[i]) begin
                if (v_in >= trial) begin
                    rv_reg[i] <= v_in - trial;
                    rr_reg[i] <= (r_in >> 1) + RBIT;
                end else begin
                    rv_reg[i] <= v_in;
                    rr_reg[i] <= r_in >> 1;
                end
            end
        end
    end

    // a*b times root in two partial products, their sum, then the quotient saturation test
    always_ff @(posedge aclk) begin
        if (en[MUL_ST]) begin
            pl_reg <= 63'(ab[30:0]) * 63'(rr_reg[ROOT_ST-1][31:0]);
            ph_reg <= 63'(ab[61:31]) * 63'(rr_reg[ROOT_ST-1][31:0]);
        end
        if (en[SUM_ST]) begin
            num_reg <= {ph_reg, 31'd0} + 94'(pl_reg);
        end
        if (en[SAT_ST]) begin
            rem_reg[0] <= num_reg;
            sat_reg[0] <= 95'(num_reg) >= (95'(side_reg[SUM_ST].c) << QUO_ST);
        end
    end

    // Restoring division, one quotient bit per stage
    for (genvar j = 0; j < QUO_ST; j++) begin : g_div
        localparam int unsigned QB = QUO_ST - 1 - j;
        logic [94:0] dsh;
        logic        take;
        logic [30:0] q_in;

        assign dsh  = 95'(side_reg[DIV_ST+j-1].c) << QB;
        assign take = 95'(rem_reg[j]) >= dsh;

        if (j == 0) begin : g_first
            assign q_in = '0;
        end else begin : g_next
            assign q_in = q_reg[j-1];
        end

        always_ff @(posedge aclk) begin
            if (en[DIV_ST+j]) begin
                rem_reg[j+1] <= take ? 94'(95'(rem_reg[j]) - dsh) : rem_reg[j];
                q_reg[j]     <= q_in | (31'(take) << QB);
                sat_reg[j+1] <= sat_reg[j];
            end
        end
    end

    // Doubled quotient, saturating at the 32-bit limit
    assign chord.chord = sat_reg[QUO_ST] ? 32'hFFFF_FFFF : {q_reg[QUO_ST-1], 1'b0};
    assign chord.hit   = side_reg[CHORD_ST-1].hit;
    assign chord.prior = side_reg[CHORD_ST-1].prior;

endmodule

>>> rtl/erp_accum.sv
// Density scaling of the chord and saturating add to the running sum.
`timescale 1ns / 1ps

module erp_accum
    import erp_pkg::*;
(
    input  logic               aclk,
    input  logic [ACC_ST-1:0]  en,
    input  erp_chord_t         chord,
    input  logic signed [31:0] density,
    output erp_out_t           result
);

    logic        [63:0] prod_reg;
    logic               neg_reg;
    logic               hit_reg   [0:1];
    logic signed [31:0] prior_reg [0:1];
    logic        [48:0] m_next;
    logic signed [49:0] term_reg;
    logic signed [50:0] sum_next;
    erp_out_t           out_reg;

    assign m_next   = 49'((65'(prod_reg) + 65'd32768) >> 16);
    assign sum_next = 51'(prior_reg[1]) + 51'(term_reg);

    always_ff @(posedge aclk) begin
        // Stage 0: density magnitude times chord
        if (en[0]) begin
            prod_reg     <= 64'(abs32(density)) * 64'(chord.chord);
            neg_reg      <= density[31];
            hit_reg[0]   <= chord.hit;
            prior_reg[0] <= chord.prior;
        end
        // Stage 1: round to Q16.16, apply sign, drop on a miss
        if (en[1]) begin
            if (!hit_reg[0]) begin
                term_reg <= '0;
            end else if (neg_reg) begin
                term_reg <= $signed(50'd0 - 50'(m_next));
            end else begin
                term_reg <= $signed(50'(m_next));
            end
            hit_reg[1]   <= hit_reg[0];
            prior_reg[1] <= prior_reg[0];
        end
        // Stage 2: saturating add
        if (en[2]) begin
            if (sum_next > 51'sd2147483647) begin
                out_reg.new_sum <= 32'sh7FFF_FFFF;
            end else if (sum_next < -51'sd2147483648) begin
                out_reg.new_sum <= 32'sh8000_0000;
            end else begin
                out_reg.new_sum <= sum_next[31:0];
            end
            out_reg.hit <= hit_reg[1];
        end
    end

    assign result = out_reg;

endmodule

>>> rtl/ellipse_ray_projection.sv
// Top level of the fan-beam ellipse projector.
//
// Usage: load the ellipse through the configuration port (cfg_wen, cfg_index,
// cfg_wdata; indexes 0..5 are centre radius, centre angle, orientation,
// semi-axis a, semi-axis b, density; other indexes are ignored) while no ray
// is in flight. Rays enter on the s_ channel as valid/ready transactions and
// each produces exactly one result on the m_ channel, in order: the running
// sum plus density times chord on a hit, saturated, and a hit flag.
// From acceptance to m_valid a ray passes a single input stage, the three
// parallel sine/cosine pipelines, geometry, the one bit per stage square
// root, the scaling product, the one bit per stage quotient and the density
// multiply and saturating add. Throughput is one ray per cycle while the
// receiver keeps m_ready high. Each stage has its own valid bit and
// advances when it is empty or the next stage advances, so when the receiver
// stalls the pipeline still fills its bubbles and s_ready drops only when
// every stage holds a ray. Synchronous reset (aresetn low) empties the
// pipeline and clears all configuration registers to zero.
`timescale 1ns / 1ps

module ellipse_ray_projection
    import erp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  erp_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output erp_out_t              m_data
);

    localparam int unsigned GEOM_BASE  = 1 + TRIG_ST;
    localparam int unsigned CHORD_BASE = GEOM_BASE + GEOM_ST;
    localparam int unsigned ACC_BASE   = CHORD_BASE + CHORD_ST;

    logic        [30:0] radius_reg;
    logic        [15:0] cangle_reg;
    logic        [15:0] orient_reg;
    logic        [30:0] axis_a_reg;
    logic        [30:0] axis_b_reg;
    logic signed [31:0] density_reg;
    logic        [61:0] ab_reg;

    logic [NST-1:0] valid_reg;
    logic [NST-1:0] en;

    erp_in_t     item_reg [0:TRIG_ST];
    logic [15:0] phi_reg;
    logic [15:0] dcen_reg;
    logic [15:0] dori_reg;
    erp_trig_t   tphi;
    erp_trig_t   tcen;
    erp_trig_t   tori;
    erp_geom_t   geom;
    erp_chord_t  chord;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg  <= '0;
            cangle_reg  <= '0;
            orient_reg  <= '0;
            axis_a_reg  <= '0;
            axis_b_reg  <= '0;
            density_reg <= '0;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                REG_CENTRE_RADIUS: radius_reg  <= cfg_wdata[30:0];
                REG_CENTRE_ANGLE:  cangle_reg  <= cfg_wdata[15:0];
                REG_ORIENTATION:   orient_reg  <= cfg_wdata[15:0];
                REG_SEMI_AXIS_A:   axis_a_reg  <= cfg_wdata[30:0];
                REG_SEMI_AXIS_B:   axis_b_reg  <= cfg_wdata[30:0];
                REG_DENSITY:       density_reg <= $signed(cfg_wdata);
                default: ;
            endcase
        end
    end

    // a*b, refreshed every cycle from the static configuration
    always_ff @(posedge aclk) begin
        ab_reg <= 62'(axis_a_reg) * 62'(axis_b_reg);
    end

    // Stage enables: a stage moves when empty or when its successor moves
    assign en[NST-1] = !valid_reg[NST-1] || m_ready;
    for (genvar k = 0; k < NST - 1; k++) begin : g_en
        assign en[k] = !valid_reg[k] || en[k+1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (en[0]) valid_reg[0] <= s_valid;
            for (int k = 1; k < NST; k++) begin
                if (en[k]) valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    assign s_ready = en[0];
    assign m_valid = valid_reg[NST-1];

    // Input stage with angle differences, then payload delay over trig
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            item_reg[0] <= s_data;
            phi_reg     <= s_data.ray_angle;
            dcen_reg    <= cangle_reg - s_data.ray_angle;
            dori_reg    <= orient_reg - s_data.ray_angle;
        end
        for (int k = 1; k <= TRIG_ST; k++) begin
            if (en[k]) item_reg[k] <= item_reg[k-1];
        end
    end

    erp_trig u_trig_phi (
        .aclk  (aclk),
        .en    (en[1 +: TRIG_ST]),
        .angle (phi_reg),
        .trig  (tphi)
    );

    erp_trig u_trig_cen (
        .aclk  (aclk),
        .en    (en[1 +: TRIG_ST]),
        .angle (dcen_reg),
        .trig  (tcen)
    );

    erp_trig u_trig_ori (
        .aclk  (aclk),
        .en    (en[1 +: TRIG_ST]),
        .angle (dori_reg),
        .trig  (tori)
    );

    erp_geom u_geom (
        .aclk   (aclk),
        .en     (en[GEOM_BASE +: GEOM_ST]),
        .tphi   (tphi),
        .tcen   (tcen),
        .tori   (tori),
        .item   (item_reg[TRIG_ST]),
        .radius (radius_reg),
        .axis_a (axis_a_reg),
        .axis_b (axis_b_reg),
        .geom   (geom)
    );

    erp_chord u_chord (
        .aclk  (aclk),
        .en    (en[CHORD_BASE +: CHORD_ST]),
        .geom  (geom),
        .ab    (ab_reg),
        .chord (chord)
    );

    erp_accum u_accum (
        .aclk    (aclk),
        .en      (en[ACC_BASE +: ACC_ST]),
        .chord   (chord),
        .density (density_reg),
        .result  (m_data)
    );

    // Reset empties every stage
    assert property (@(posedge aclk) !aresetn |=> valid_reg == '0)
        else $error("pipeline not empty after reset");

    // A full pipeline facing a stalled receiver takes no new transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        (&valid_reg) && !m_ready |-> !s_ready)
        else $error("input accepted into a full stalled pipeline");

    // A stalled result stays in the last stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result lost or changed");

    // One transaction entering and none leaving grows the pipeline by one
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !(m_valid && m_ready)
        |=> $countones(valid_reg) == $countones($past(valid_reg)) + 1)
        else $error("transaction lost or duplicated in pipeline");

endmodule

>>> sim/ellipse_ray_projection_tb.sv
// Self-checking testbench for the ellipse ray projector: directed and random rays against a fixed-point predictor.
`timescale 1ns / 1ps

module ellipse_ray_projection_tb;
    import erp_pkg::*;

    localparam longint unsigned Q30 = 64'd1073741824;
    localparam longint unsigned HALF_PI = 64'd1686629713;
    localparam int LATENCY = 91;
    localparam int CYCLE_LIMIT = 400000;

    logic            aclk = 1'b0;
    logic            aresetn = 1'b0;
    logic            cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic            s_valid = 1'b0;
    logic            s_ready;
    erp_in_t         s_data = '0;
    logic            m_valid;
    logic            m_ready = 1'b0;
    erp_out_t        m_data;

    ellipse_ray_projection dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Ellipse registers as the predictor sees them
    longint unsigned el_radius, el_axis_a, el_axis_b;
    logic [15:0]     el_angle, el_orient;
    longint          el_density;

    erp_in_t  ray_queue[$];
    erp_out_t sum_queue[$];
    int       mismatches = 0;
    int       hit_count = 0;
    int       ray_count = 0;
    int       cycle_count = 0;
    int       burst_left = 0;
    int       gap_left = 0;
    int       stall_phase = 0;

    // Truncating Horner step
    function automatic longint unsigned horner(longint unsigned t2, longint unsigned inner,
                                               longint unsigned k);
        return Q30 - ((t2 * inner) >> 30) / k;
    endfunction

    // Cosine and sine of a turn fraction in signed Q30
    function automatic void turn_trig(input logic [15:0] ang, output longint co,
                                      output longint si);
        longint unsigned t, t2, inner, sv, cv, v;
        t = (longint'(ang[13:0]) * HALF_PI) >> 14;
        t2 = (t * t) >> 30;
        inner = horner(t2, Q30, 110);
        inner = horner(t2, inner, 72);
        inner = horner(t2, inner, 42);
        inner = horner(t2, inner, 20);
        inner = horner(t2, inner, 6);
        sv = (t * inner) >> 30;
        if (sv > Q30) sv = Q30;
        inner = horner(t2, Q30, 90);
        inner = horner(t2, inner, 56);
        inner = horner(t2, inner, 30);
        inner = horner(t2, inner, 12);
        v = ((t2 * inner) >> 30) / 2;
        cv = (v >= Q30) ? 0 : Q30 - v;
        case (ang[15:14])
            2'd0: begin co = cv; si = sv; end
            2'd1: begin co = -longint'(sv); si = cv; end
            2'd2: begin co = -longint'(cv); si = -longint'(sv); end
            default: begin co = sv; si = -longint'(cv); end
        endcase
    endfunction

    // Value times Q30 factor, rounded half away from zero
    function automatic longint scale_q30(longint v, longint k);
        longint unsigned mv, mk, r;
        mv = v < 0 ? -v : v;
        mk = k < 0 ? -k : k;
        r = (mv * mk + (64'd1 << 29)) >> 30;
        return ((v < 0) != (k < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Projection of one ray through the current ellipse
    function automatic erp_out_t project_ray(erp_in_t r);
        longint cphi, sphi, cd, sd, ca, sa, s, sum;
        longint unsigned ms, s2, ac, bs, c, chord, mag, m;
        logic [127:0] num, quo;
        erp_out_t res;
        turn_trig(r.ray_angle, cphi, sphi);
        turn_trig(el_angle - r.ray_angle, cd, sd);
        turn_trig(el_orient - r.ray_angle, ca, sa);
        s = scale_q30(longint'(r.source_x), cphi) + scale_q30(longint'(r.source_y), sphi)
            - scale_q30(longint'(el_radius), cd) - scale_q30(longint'(r.shift_x), cphi);
        ac = scale_q30(longint'(el_axis_a), ca < 0 ? -ca : ca);
        bs = scale_q30(longint'(el_axis_b), sa < 0 ? -sa : sa);
        c = ac * ac + bs * bs;
        ms = s < 0 ? -s : s;
        sum = longint'(r.prior_sum);
        res.hit = 1'b0;
        if (ms < (64'd1 << 32)) begin
            s2 = ms * ms;
            if (s2 < c) begin
                res.hit = 1'b1;
                num = 128'(el_axis_a * el_axis_b) * 128'(floor_sqrt(c - s2));
                quo = num / 128'(c);
                chord = (quo >= 128'h8000_0000) ? 64'hFFFF_FFFF : 64'(quo) * 2;
                mag = el_density < 0 ? -el_density : el_density;
                m = (mag * chord + 64'd32768) >> 16;
                sum += (el_density < 0) ? -longint'(m) : longint'(m);
                if (sum > 64'sd2147483647) sum = 64'sd2147483647;
                if (sum < -64'sd2147483648) sum = -64'sd2147483648;
            end
        end
        res.new_sum = sum[31:0];
        return res;
    endfunction

    // Input driver: bursts with random gaps
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sum_queue.push_back(project_ray(s_data));
                ray_count <= ray_count + 1;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (ray_queue.size() > 0) begin
                    s_valid <= 1'b1;
                    s_data <= ray_queue.pop_front();
                    if (burst_left > 0) begin
                        burst_left <= burst_left - 1;
                    end else begin
                        burst_left <= $urandom_range(40, 1);
                        gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with its own stall pattern
    always @(posedge aclk) begin
        erp_out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (sum_queue.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) $display("Unexpected result %h", m_data);
                end else begin
                    want = sum_queue.pop_front();
                    if (m_data.hit !== want.hit) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10) $display("hit: exp %b got %b", want.hit, m_data.hit);
                    end else if (m_data.new_sum !== want.new_sum) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("new_sum: exp %h got %h", want.new_sum, m_data.new_sum);
                    end
                    if (want.hit) hit_count <= hit_count + 1;
                end
            end
            stall_phase <= (stall_phase + 1) % 64;
            if (stall_phase < 24) m_ready <= 1'b1;
            else if (stall_phase < 40) m_ready <= ($urandom_range(2, 0) != 0);
            else m_ready <= ($urandom_range(3, 0) == 0);
        end
    end

    // Timeout watchdog
    always @(posedge aclk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        case (idx)
            REG_CENTRE_RADIUS: el_radius = val[30:0];
            REG_CENTRE_ANGLE:  el_angle = val[15:0];
            REG_ORIENTATION:   el_orient = val[15:0];
            REG_SEMI_AXIS_A:   el_axis_a = val[30:0];
            REG_SEMI_AXIS_B:   el_axis_b = val[30:0];
            REG_DENSITY:       el_density = longint'(signed'(val));
            default: ;
        endcase
    endtask

    task automatic load_ellipse(input logic [31:0] rad, input logic [15:0] ang,
                                input logic [15:0] orient, input logic [31:0] ea,
                                input logic [31:0] eb, input logic [31:0] dens);
        write_reg(REG_CENTRE_RADIUS, rad);
        write_reg(REG_CENTRE_ANGLE, {16'hFFFF, ang});
        write_reg(REG_ORIENTATION, {16'hA5A5, orient});
        write_reg(REG_SEMI_AXIS_A, ea);
        write_reg(REG_SEMI_AXIS_B, eb);
        write_reg(REG_DENSITY, dens);
        write_reg(3'd7, $urandom);
    endtask

    // Mostly rays that pass near the ellipse, some anywhere
    function automatic erp_in_t make_ray();
        erp_in_t r;
        r.ray_angle = $urandom;
        r.prior_sum = $urandom;
        if ($urandom_range(3, 0) == 0) begin
            r.source_x = $urandom;
            r.source_y = $urandom;
            r.shift_x = $urandom;
        end else begin
            r.source_x = $signed($urandom_range(32'h00A0_0000, 0)) - 32'sh0050_0000;
            r.source_y = $signed($urandom_range(32'h00A0_0000, 0)) - 32'sh0050_0000;
            r.shift_x = ($urandom_range(1, 0) == 0) ? 0 :
                        $signed($urandom_range(32'h0004_0000, 0)) - 32'sh0002_0000;
        end
        if ($urandom_range(7, 0) == 0) r.prior_sum = {$urandom_range(1, 0) ? 2'b01 : 2'b10, 30'h0};
        return r;
    endfunction

    function automatic erp_in_t mk(input logic [31:0] x, input logic [31:0] y,
                                   input logic [15:0] a, input logic [31:0] sh,
                                   input logic [31:0] p);
        erp_in_t r;
        r.source_x = x; r.source_y = y; r.ray_angle = a; r.shift_x = sh; r.prior_sum = p;
        return r;
    endfunction

    // Sampled at the falling edge so that the driver's updates have settled
    task automatic drain();
        while (ray_queue.size() > 0 || s_valid || sum_queue.size() > 0) @(negedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    initial begin
        el_radius = 0; el_axis_a = 0; el_axis_b = 0;
        el_angle = 0; el_orient = 0; el_density = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Degenerate reset ellipse: every ray misses
        ray_queue.push_back(mk(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 32'h8000_0000, 32'h1234));
        ray_queue.push_back(mk(0, 0, 0, 0, 32'h8000_0000));
        drain();

        // Unit circle at the origin, unit density: chords and quadrants
        load_ellipse(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        for (int q = 0; q < 4; q++)
            ray_queue.push_back(mk(32'h0000_8000, 0, 16'(q * 16384), 0, 0));
        ray_queue.push_back(mk(32'h0000_8000, 32'h0000_4000, 16'h2000, 32'h0000_1000, 32'h7FFF_FFF0));
        ray_queue.push_back(mk(32'h0002_0000, 0, 0, 0, 32'h0000_0100));
        ray_queue.push_back(mk(32'h8000_0000, 32'h7FFF_FFFF, 16'h6000, 32'h7FFF_FFFF, 0));
        drain();

        // Huge axes, extreme density: chord and sum saturation
        load_ellipse(32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF);
        ray_queue.push_back(mk(0, 0, 16'hFFFF, 0, 32'h7FFF_0000));
        ray_queue.push_back(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h8000, 0, 0));
        drain();
        load_ellipse(32'h0001_0000, 16'h4000, 16'h1000, 32'h0000_0001, 32'h7FFF_FFFF,
                     32'h8000_0000);
        ray_queue.push_back(mk(0, 32'h0001_0000, 16'h4000, 0, 32'h8000_0100));
        ray_queue.push_back(mk(0, 32'h0001_0000, 16'h4000, 0, 0));
        drain();
        // Zero axis and zero density hits
        load_ellipse(0, 0, 16'h3000, 0, 32'h0003_0000, 32'h0002_0000);
        ray_queue.push_back(mk(0, 0, 16'h1000, 0, 32'h55));
        drain();
        load_ellipse(0, 0, 0, 32'h0002_0000, 32'h0001_0000, 0);
        ray_queue.push_back(mk(0, 0, 0, 0, 32'h77));
        drain();

        // Random ellipses, each with a batch of rays
        for (int phase = 0; phase < 9; phase++) begin
            load_ellipse($urandom_range(32'h0030_0000, 0), $urandom, $urandom,
                         $urandom_range(32'h0040_0000, 32'h0000_8000),
                         $urandom_range(32'h0040_0000, 32'h0000_8000),
                         (phase == 8) ? $urandom : $signed($urandom_range(32'h0008_0000, 0))
                                                  - 32'sh0004_0000);
            for (int i = 0; i < 48; i++) ray_queue.push_back(make_ray());
            drain();
        end

        $display("Projected %0d rays over 15 ellipse settings, %0d crossed the ellipse",
                 ray_count, hit_count);
        if (mismatches == 0) $display("Regression PASS");
        else begin
            $display("%0d mismatches", mismatches);
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

>>> ellipse_ray_projection.f
rtl/erp_pkg.sv
rtl/erp_trig.sv
rtl/erp_geom.sv
rtl/erp_chord.sv
rtl/erp_accum.sv
rtl/ellipse_ray_projection.sv
sim/ellipse_ray_projection_tb.sv
